// ----- rtl/xor_delta_zero_chunk_encoder_unit_defines.svh -----
// ----------------------------------------------------------------------------
// XOR delta zero chunk encoder - assertion macros
// Shorthand for the clocked, reset-qualified checks used by the encoder.
// ----------------------------------------------------------------------------
`ifndef XOR_DELTA_ZERO_CHUNK_ENCODER_UNIT_DEFINES_SVH
`define XOR_DELTA_ZERO_CHUNK_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define XDZC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define XDZC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/xdzc_pkg.sv -----
// ----------------------------------------------------------------------------
// XOR delta zero chunk encoder - package
// Payload types, codes, fixed sizes and the derivation of the per-snapshot
// constants that follow from the length and capacity registers.
// ----------------------------------------------------------------------------
package xdzc_pkg;

	localparam int ADDR_W      = 25;
	localparam int LEN_W       = 25;
	localparam int WORD_W      = 64;
	localparam int BYTES_W     = 4;
	localparam int WORD_IDX_W  = 22;
	localparam int CHUNK_BYTES = 4096;
	localparam int MAX_SNAPSHOT_BYTES = 16777216;
	localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);
	localparam int WOFF_W      = CHUNK_SHIFT - 3;
	localparam int CHUNK_IDX_W = WORD_IDX_W - WOFF_W;
	localparam int CHUNKS_W    = LEN_W - CHUNK_SHIFT + 1;
	localparam int BMAP_LEN_W  = CHUNKS_W - 3;
	localparam int BASE_W      = BMAP_LEN_W + 1;
	localparam int SPAN_W      = CHUNK_SHIFT + 1;
	localparam int HDR_BYTES   = 12;
	localparam logic [31:0] HDR_MAGIC = 32'h4653_5A43;

	localparam logic [LEN_W-1:0] RESET_SNAPSHOT_BYTES = LEN_W'(16777216);
	localparam logic [LEN_W-1:0] RESET_DEST_CAPACITY  = LEN_W'(16777740);

	// Configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 25;
	localparam logic [CFG_INDEX_W-1:0] REG_DELTA_MODE     = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_SNAPSHOT_BYTES = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] REG_DEST_CAPACITY  = CFG_INDEX_W'(2);

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_BITMAP  = 2'd1,
		KIND_HEADER  = 2'd2,
		KIND_DONE    = 2'd3
	} kind_t;

	typedef struct packed {
		logic [WORD_W-1:0] state_word;
		logic [WORD_W-1:0] reference_word;
	} in_t;

	typedef struct packed {
		kind_t              out_kind;
		logic [ADDR_W-1:0]  out_addr;
		logic [WORD_W-1:0]  out_payload;
		logic [BYTES_W-1:0] out_bytes;
		logic               run_last;
	} out_t;

	// Constants of one snapshot, held while a run is in progress
	typedef struct packed {
		logic [LEN_W-1:0]      len;
		logic [BASE_W-1:0]     base;
		logic [WORD_IDX_W-1:0] last_word_idx;
		logic [BYTES_W-1:0]    last_bytes;
		logic [SPAN_W-1:0]     last_span;
		logic                  cap_ok;
	} derived_t;

	function automatic derived_t derive(input logic [LEN_W-1:0] snap,
			input logic [LEN_W-1:0] dest);
		derived_t d;
		logic [LEN_W-1:0] n;
		logic [LEN_W-1:0] n_m1;
		logic [CHUNKS_W-1:0] chunks;
		logic [BMAP_LEN_W-1:0] bmap_len;
		logic [LEN_W:0] need;
		if (snap == '0) begin
			n = LEN_W'(1);
		end else if (snap > LEN_W'(MAX_SNAPSHOT_BYTES)) begin
			n = LEN_W'(MAX_SNAPSHOT_BYTES);
		end else begin
			n = snap;
		end
		n_m1 = n - LEN_W'(1);
		// ceil(n / chunk) and ceil(chunks / 8) via (x-1)/d + 1
		chunks = CHUNKS_W'(n_m1 >> CHUNK_SHIFT) + CHUNKS_W'(1);
		bmap_len = BMAP_LEN_W'((chunks - CHUNKS_W'(1)) >> 3) + BMAP_LEN_W'(1);
		d.len = n;
		d.base = BASE_W'(HDR_BYTES) + BASE_W'(bmap_len);
		need = (LEN_W+1)'(d.base) + (LEN_W+1)'(n);
		d.cap_ok = ({1'b0, dest} >= need);
		d.last_word_idx = WORD_IDX_W'(n_m1 >> 3);
		d.last_bytes = BYTES_W'(n_m1[2:0]) + BYTES_W'(1);
		d.last_span = SPAN_W'(n_m1[CHUNK_SHIFT-1:0]) + SPAN_W'(1);
		return d;
	endfunction

endpackage

// ----- rtl/xor_delta_zero_chunk_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// XOR delta zero chunk encoder
// Codes a snapshot word stream into a chunk-suppressed image of writes.
// ----------------------------------------------------------------------------
// Users, read this first. Each request carries one 64-bit snapshot word and its
// reference word. In delta mode the coded word is state XOR reference, in
// keyframe mode it is the state word alone; on the final word only the bytes
// inside snapshot_bytes count. The snapshot is cut into 4096-byte chunks and
// each coded word comes out as a payload write at 12 + bitmap length + data
// position + offset in chunk. The data position moves past a chunk only when
// that chunk held a non-zero byte, so an all-zero chunk is overwritten by the
// next one. A bitmap byte write follows every eighth chunk and the final
// chunk; the final word also yields the two header writes (magic and length,
// then chunk size) and a completion carrying the total image length. If
// dest_capacity cannot hold the image, only the completion comes out, with 0.
// Timing: the writes of a word are built in the cycle that it is taken, into a
// five-slot result register; the result port sends one write per cycle while
// out_stall is low. A word that yields at most one write therefore sustains one
// word per cycle while out_stall is low; a word that closes a group of eight
// chunks yields two writes and the final word up to five, which the single
// result port sends in turn. Writing a configuration register restarts the run;
// do it only while the block is idle. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "xor_delta_zero_chunk_encoder_unit_defines.svh"

module xor_delta_zero_chunk_encoder_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  xdzc_pkg::in_t                         in_item,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output xdzc_pkg::out_t                        out_item,
	input  logic                                  cfg_we,
	input  logic [xdzc_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [xdzc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

	localparam int NSLOT = 5;
	localparam int SLOT_PAY  = 0;
	localparam int SLOT_BMAP = 1;
	localparam int SLOT_HDR0 = 2;
	localparam int SLOT_HDR1 = 3;
	localparam int SLOT_DONE = 4;

	// Configuration and derived snapshot constants
	logic                               delta_mode_q;
	logic [xdzc_pkg::LEN_W-1:0]         snapshot_bytes_q;
	logic [xdzc_pkg::LEN_W-1:0]         dest_capacity_q;
	xdzc_pkg::derived_t                 drv_q;
	xdzc_pkg::derived_t                 drv_nx;
	logic [xdzc_pkg::LEN_W-1:0]         snap_nx;
	logic [xdzc_pkg::LEN_W-1:0]         dest_nx;
	logic                               cfg_hit;

	// Run state
	logic                               capacity_ok_q;
	logic [xdzc_pkg::WORD_IDX_W-1:0]    word_index_q;
	logic                               chunk_nonzero_q;
	logic [7:0]                         bitmap_acc_q;
	logic [xdzc_pkg::ADDR_W-1:0]        payload_pos_q;

	// Result register
	xdzc_pkg::out_t                     slot_q [NSLOT];
	xdzc_pkg::out_t                     slot_nx [NSLOT];
	logic [NSLOT-1:0]                   mask_q;
	logic [NSLOT-1:0]                   mask_nx;
	logic [NSLOT-1:0]                   mask_rest;
	logic                               mask_single;

	// Per-word datapath
	logic                               accept;
	logic                               take;
	logic [xdzc_pkg::WOFF_W-1:0]        woff;
	logic [xdzc_pkg::CHUNK_IDX_W-1:0]   chunk_idx;
	logic                               last_word;
	logic                               chunk_end;
	logic                               bitmap_emit;
	logic [xdzc_pkg::BYTES_W-1:0]       nb;
	logic [xdzc_pkg::WORD_W-1:0]        coded_raw;
	logic [xdzc_pkg::WORD_W-1:0]        coded;
	logic                               nz_new;
	logic [7:0]                         acc_new;
	logic [xdzc_pkg::ADDR_W-1:0]        span;
	logic [xdzc_pkg::ADDR_W-1:0]        pos_after;
	logic [xdzc_pkg::ADDR_W-1:0]        done_len;
	logic [xdzc_pkg::ADDR_W-1:0]        pay_addr;
	logic [xdzc_pkg::ADDR_W-1:0]        bmap_addr;

	// ---------------------------------------------------------------- handshake
	// Take a new request when the result register is empty, or when its last
	// pending write leaves in this cycle.
	assign mask_rest   = mask_q & (mask_q - NSLOT'(1));
	assign mask_single = (mask_q != '0) && (mask_rest == '0);
	assign out_valid   = (mask_q != '0);
	assign take        = out_valid && !out_stall;
	assign in_stall    = !((mask_q == '0) || (mask_single && !out_stall));
	assign accept      = in_valid && !in_stall;

	// ------------------------------------------------------------ configuration
	assign cfg_hit = cfg_we && ((cfg_index == xdzc_pkg::REG_DELTA_MODE)
		|| (cfg_index == xdzc_pkg::REG_SNAPSHOT_BYTES)
		|| (cfg_index == xdzc_pkg::REG_DEST_CAPACITY));
	assign snap_nx = (cfg_we && cfg_index == xdzc_pkg::REG_SNAPSHOT_BYTES)
		? xdzc_pkg::LEN_W'(cfg_wdata) : snapshot_bytes_q;
	assign dest_nx = (cfg_we && cfg_index == xdzc_pkg::REG_DEST_CAPACITY)
		? xdzc_pkg::LEN_W'(cfg_wdata) : dest_capacity_q;
	// Recompute length, bitmap base and the capacity check from the values
	// being written, so they are valid in the very next cycle.
	assign drv_nx = xdzc_pkg::derive(snap_nx, dest_nx);

	// ---------------------------------------------------------------- datapath
	assign woff      = word_index_q[xdzc_pkg::WOFF_W-1:0];
	assign chunk_idx = word_index_q[xdzc_pkg::WORD_IDX_W-1:xdzc_pkg::WOFF_W];
	assign last_word = (word_index_q == drv_q.last_word_idx);
	assign chunk_end = last_word || (&woff);
	assign bitmap_emit = chunk_end && ((&chunk_idx[2:0]) || last_word);
	assign nb = last_word ? drv_q.last_bytes : xdzc_pkg::BYTES_W'(8);

	assign coded_raw = delta_mode_q ? (in_item.state_word ^ in_item.reference_word)
		: in_item.state_word;

	// Drop the bytes past the snapshot end on a partial final word
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			coded[i*8 +: 8] = (xdzc_pkg::BYTES_W'(i) < nb) ? coded_raw[i*8 +: 8] : 8'd0;
		end
	end

	assign nz_new  = chunk_nonzero_q || (coded != '0);
	assign acc_new = bitmap_acc_q | (nz_new ? (8'd1 << chunk_idx[2:0]) : 8'd0);
	assign span    = last_word ? xdzc_pkg::ADDR_W'(drv_q.last_span)
		: xdzc_pkg::ADDR_W'(xdzc_pkg::CHUNK_BYTES);
	assign pos_after = payload_pos_q + (nz_new ? span : '0);
	assign done_len  = xdzc_pkg::ADDR_W'(drv_q.base) + pos_after;
	assign pay_addr  = xdzc_pkg::ADDR_W'(drv_q.base) + payload_pos_q
		+ xdzc_pkg::ADDR_W'({woff, 3'b000});
	assign bmap_addr = xdzc_pkg::ADDR_W'(xdzc_pkg::HDR_BYTES)
		+ xdzc_pkg::ADDR_W'(chunk_idx >> 3);

	// Build every write this word can cause; the mask says which ones exist.
	always_comb begin
		slot_nx[SLOT_PAY].out_kind    = xdzc_pkg::KIND_PAYLOAD;
		slot_nx[SLOT_PAY].out_addr    = pay_addr;
		slot_nx[SLOT_PAY].out_payload = coded;
		slot_nx[SLOT_PAY].out_bytes   = nb;
		slot_nx[SLOT_PAY].run_last    = 1'b0;

		slot_nx[SLOT_BMAP].out_kind    = xdzc_pkg::KIND_BITMAP;
		slot_nx[SLOT_BMAP].out_addr    = bmap_addr;
		slot_nx[SLOT_BMAP].out_payload = xdzc_pkg::WORD_W'(acc_new);
		slot_nx[SLOT_BMAP].out_bytes   = xdzc_pkg::BYTES_W'(1);
		slot_nx[SLOT_BMAP].run_last    = 1'b0;

		slot_nx[SLOT_HDR0].out_kind    = xdzc_pkg::KIND_HEADER;
		slot_nx[SLOT_HDR0].out_addr    = '0;
		slot_nx[SLOT_HDR0].out_payload = {7'd0, drv_q.len, xdzc_pkg::HDR_MAGIC};
		slot_nx[SLOT_HDR0].out_bytes   = xdzc_pkg::BYTES_W'(8);
		slot_nx[SLOT_HDR0].run_last    = 1'b0;

		slot_nx[SLOT_HDR1].out_kind    = xdzc_pkg::KIND_HEADER;
		slot_nx[SLOT_HDR1].out_addr    = xdzc_pkg::ADDR_W'(8);
		slot_nx[SLOT_HDR1].out_payload = xdzc_pkg::WORD_W'(xdzc_pkg::CHUNK_BYTES);
		slot_nx[SLOT_HDR1].out_bytes   = xdzc_pkg::BYTES_W'(4);
		slot_nx[SLOT_HDR1].run_last    = 1'b0;

		slot_nx[SLOT_DONE].out_kind    = xdzc_pkg::KIND_DONE;
		slot_nx[SLOT_DONE].out_addr    = '0;
		slot_nx[SLOT_DONE].out_payload = capacity_ok_q ? xdzc_pkg::WORD_W'(done_len) : '0;
		slot_nx[SLOT_DONE].out_bytes   = '0;
		slot_nx[SLOT_DONE].run_last    = 1'b0;

		mask_nx[SLOT_PAY]  = capacity_ok_q;
		mask_nx[SLOT_BMAP] = capacity_ok_q && bitmap_emit;
		mask_nx[SLOT_HDR0] = capacity_ok_q && last_word;
		mask_nx[SLOT_HDR1] = capacity_ok_q && last_word;
		mask_nx[SLOT_DONE] = last_word;
	end

	// -------------------------------------------------------------- result port
	// Send the lowest pending slot; the final pending one closes the request.
	always_comb begin
		priority if (mask_q[SLOT_PAY]) begin
			out_item = slot_q[SLOT_PAY];
		end else if (mask_q[SLOT_BMAP]) begin
			out_item = slot_q[SLOT_BMAP];
		end else if (mask_q[SLOT_HDR0]) begin
			out_item = slot_q[SLOT_HDR0];
		end else if (mask_q[SLOT_HDR1]) begin
			out_item = slot_q[SLOT_HDR1];
		end else begin
			out_item = slot_q[SLOT_DONE];
		end
		out_item.run_last = mask_single;
	end

	// ------------------------------------------------------------------ control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_mode_q     <= 1'b0;
			snapshot_bytes_q <= xdzc_pkg::RESET_SNAPSHOT_BYTES;
			dest_capacity_q  <= xdzc_pkg::RESET_DEST_CAPACITY;
			drv_q            <= xdzc_pkg::derive(xdzc_pkg::RESET_SNAPSHOT_BYTES,
				xdzc_pkg::RESET_DEST_CAPACITY);
			capacity_ok_q    <= 1'b1;
			word_index_q     <= '0;
			chunk_nonzero_q  <= 1'b0;
			bitmap_acc_q     <= '0;
			payload_pos_q    <= '0;
			mask_q           <= '0;
		end else begin
			if (cfg_hit) begin
				// Write, then restart the run against the new settings
				if (cfg_index == xdzc_pkg::REG_DELTA_MODE) begin
					delta_mode_q <= cfg_wdata[0];
				end
				snapshot_bytes_q <= snap_nx;
				dest_capacity_q  <= dest_nx;
				drv_q            <= drv_nx;
				capacity_ok_q    <= drv_nx.cap_ok;
				word_index_q     <= '0;
				chunk_nonzero_q  <= 1'b0;
				bitmap_acc_q     <= '0;
				payload_pos_q    <= '0;
			end else if (accept) begin
				if (last_word) begin
					// Run complete: the next request starts a new snapshot
					capacity_ok_q   <= drv_q.cap_ok;
					word_index_q    <= '0;
					chunk_nonzero_q <= 1'b0;
					bitmap_acc_q    <= '0;
					payload_pos_q   <= '0;
				end else begin
					word_index_q <= word_index_q + xdzc_pkg::WORD_IDX_W'(1);
					if (chunk_end) begin
						chunk_nonzero_q <= 1'b0;
						bitmap_acc_q    <= bitmap_emit ? 8'd0 : acc_new;
						payload_pos_q   <= pos_after;
					end else begin
						chunk_nonzero_q <= nz_new;
					end
				end
			end

			if (accept) begin
				mask_q <= mask_nx;
			end else if (take) begin
				mask_q <= mask_rest;
			end
		end
	end

	// Result slots hold payload only; the mask qualifies them
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < NSLOT; i++) begin
				slot_q[i] <= slot_nx[i];
			end
		end
	end

	// --------------------------------------------------------------- assertions
	`XDZC_ASSERT_SAME(a_done_closes_request, out_valid && out_item.out_kind == xdzc_pkg::KIND_DONE, out_item.run_last, "completion is not the last write of its request")
	`XDZC_ASSERT_SAME(a_accept_needs_drain, in_valid && !in_stall && mask_q != '0, !out_stall && mask_single, "request accepted over pending writes")
	`XDZC_ASSERT_NEXT(a_word_advance, in_valid && !in_stall && !cfg_hit, word_index_q == $past(word_index_q) + xdzc_pkg::WORD_IDX_W'(1) || word_index_q == '0, "word index skipped")

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XOR delta zero chunk encoder - testbench
// Streams snapshot words into the encoder and checks every write it emits.
// A short stimulus table drives the register extremes and the special cases:
// partial final word, short capacity, length out of range, an ignored register
// index and all-zero chunks. A random phase follows, made of many short
// snapshots and the opening words of one long snapshot that a register write
// then cuts off. An in-bench encoder model predicts each write, and each
// emitted write is compared with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CHUNK_WORDS    = xdzc_pkg::CHUNK_BYTES / 8;
	localparam int SETTLE_CYCLES  = 6;     // idle gap before a register write
	localparam int TAIL_CYCLES    = 16;
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
	localparam int LONG_WORDS     = 24;

	// Index past the register list; a write to it must be dropped
	localparam logic [xdzc_pkg::CFG_INDEX_W-1:0] REG_SPARE_INDEX =
		xdzc_pkg::CFG_INDEX_W'(3);

	typedef enum logic {ROW_WORD, ROW_CFG} row_op_t;

	// One row of the directed stimulus. For a word row, typed set means the
	// completion that this word closes must carry total.
	typedef struct packed {
		row_op_t                          op;
		logic [xdzc_pkg::CFG_INDEX_W-1:0] idx;
		logic [xdzc_pkg::CFG_DATA_W-1:0]  val;
		logic [63:0]                      st;
		logic [63:0]                      rf;
		logic                             typed;
		logic [63:0]                      total;
	} dir_row_t;

	localparam int DIR_ROWS = 32;

	// After reset: keyframe, 16 MiB snapshot, capacity exactly enough.
	dir_row_t dir_tab [DIR_ROWS] = '{
		// long snapshot at reset: first words land at 12 + 512
		'{ROW_WORD, xdzc_pkg::REG_DELTA_MODE, 25'd0, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h0123_4567_89AB_CDEF, 1'b0, 64'd0},
		'{ROW_WORD, xdzc_pkg::REG_DELTA_MODE, 25'd0, 64'h0,
			64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
		// dropped write, the run goes on
		'{ROW_CFG, REG_SPARE_INDEX, 25'h1FF_FFFF, 64'd0, 64'd0, 1'b0, 64'd0},
		'{ROW_WORD, xdzc_pkg::REG_DELTA_MODE, 25'd0, 64'h8000_0000_0000_0001,
			64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
		// length 0 acts as one byte
		'{ROW_CFG, xdzc_pkg::REG_SNAPSHOT_BYTES, 25'd0, 64'd0, 64'd0, 1'b0, 64'd0},
		'{ROW_WORD, xdzc_pkg::REG_DELTA_MODE, 25'd0, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h0, 1'b1, 64'd14},
		// delta of equal words is an empty chunk
		'{ROW_CFG, xdzc_pkg::REG_DELTA_MODE, 25'd1, 64'd0, 64'd0, 1'b0, 64'd0},
		'{ROW_WORD, xdzc_pkg::REG_DELTA_MODE, 25'd0, 64'hA5A5_A5A5_A5A5_A5A5,
			64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 64'd13},
		// 13 bytes: second word keeps its low five bytes only
		'{ROW_CFG, xdzc_pkg::REG_SNAPSHOT_BYTES, 25'd13, 64'd0, 64'd0, 1'b0, 64'd0},
		'{ROW_WORD, xdzc_pkg::REG_DELTA_MODE, 25'd0, 64'h0000_0000_0000_00FF,
			64'h0, 1'b0, 64'd0},
		'{ROW_WORD, xdzc_pkg::REG_DELTA_MODE, 25'd0, 64'hFFFF_FF00_0000_0000,
			64'h0, 1'b1, 64'd26},
		'{ROW_WORD, xdzc_pkg::REG_DELTA_MODE, 25'd0, 64'h0, 64'h0, 1'b0, 64'd0},
		'{ROW_WORD, xdzc_pkg::REG_DELTA_MODE, 25'd0, 64'h0000_0012_0000_0000,
			64'h0, 1'b1, 64'd26},
		// one byte short of the image: completion only, with 0
		'{ROW_CFG, xdzc_pkg::REG_DEST_CAPACITY, 25'd25, 64'd0, 64'd0, 1'b0, 64'd0},
		'{ROW_WORD, xdzc_pkg::REG_DELTA_MODE, 25'd0, 64'h1, 64'h0, 1'b0, 64'd0},
		'{ROW_WORD, xdzc_pkg::REG_DELTA_MODE, 25'd0, 64'h1, 64'h0, 1'b1, 64'd0},
		// exact fit
		'{ROW_CFG, xdzc_pkg::REG_DEST_CAPACITY, 25'd26, 64'd0, 64'd0, 1'b0, 64'd0},
		'{ROW_WORD, xdzc_pkg::REG_DELTA_MODE, 25'd0, 64'h0, 64'h0, 1'b0, 64'd0},
		'{ROW_WORD, xdzc_pkg::REG_DELTA_MODE, 25'd0, 64'h0, 64'h0, 1'b1, 64'd13},
		// no room at all
		'{ROW_CFG, xdzc_pkg::REG_DEST_CAPACITY, 25'd0, 64'd0, 64'd0, 1'b0, 64'd0},
		'{ROW_CFG, xdzc_pkg::REG_SNAPSHOT_BYTES, 25'd0, 64'd0, 64'd0, 1'b0, 64'd0},
		'{ROW_WORD, xdzc_pkg::REG_DELTA_MODE, 25'd0, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h0, 1'b1, 64'd0},
		// oversize length saturates to 16 MiB
		'{ROW_CFG, xdzc_pkg::REG_DEST_CAPACITY, 25'h1FF_FFFF, 64'd0, 64'd0, 1'b0, 64'd0},
		'{ROW_CFG, xdzc_pkg::REG_SNAPSHOT_BYTES, 25'h1FF_FFFF, 64'd0, 64'd0, 1'b0, 64'd0},
		'{ROW_WORD, xdzc_pkg::REG_DELTA_MODE, 25'd0, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h5555_5555_5555_5555, 1'b0, 64'd0},
		'{ROW_WORD, xdzc_pkg::REG_DELTA_MODE, 25'd0, 64'h0, 64'h0, 1'b0, 64'd0},
		// abort the long run, then one full word
		'{ROW_CFG, xdzc_pkg::REG_DELTA_MODE, 25'd0, 64'd0, 64'd0, 1'b0, 64'd0},
		'{ROW_CFG, xdzc_pkg::REG_SNAPSHOT_BYTES, 25'd8, 64'd0, 64'd0, 1'b0, 64'd0},
		'{ROW_WORD, xdzc_pkg::REG_DELTA_MODE, 25'd0, 64'h8000_0000_0000_0000,
			64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd21},
		// keyframe ignores the reference
		'{ROW_CFG, xdzc_pkg::REG_SNAPSHOT_BYTES, 25'd16, 64'd0, 64'd0, 1'b0, 64'd0},
		'{ROW_WORD, xdzc_pkg::REG_DELTA_MODE, 25'd0, 64'h0,
			64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
		'{ROW_WORD, xdzc_pkg::REG_DELTA_MODE, 25'd0, 64'h0,
			64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd13}
	};

	// DUT ports; the inputs are all known from time zero
	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	xdzc_pkg::in_t                    in_item = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	xdzc_pkg::out_t                   out_item;
	logic                             cfg_we = 1'b0;
	logic [xdzc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [xdzc_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

	// Encoder model: register copies and run state
	logic        cfg_delta;
	logic [24:0] cfg_snap;
	logic [24:0] cfg_cap;
	logic [21:0] word_idx;
	logic [11:0] chunk_idx;
	logic [24:0] store_pos;
	logic        chunk_hit;
	logic [7:0]  bmap_acc;
	logic        cap_good;

	xdzc_pkg::out_t pending_writes[$];  // predicted writes, oldest first

	bit bursty = 1'b1;        // random idling on both channels
	int err_count = 0;
	int words_sent = 0;
	int writes_seen = 0;
	int cfg_writes = 0;
	int runs_done = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	xor_delta_zero_chunk_encoder_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Encoder model
	// ------------------------------------------------------------------------

	// Length in effect: 0 reads as 1, oversize clamps to the maximum
	function automatic logic [24:0] eff_bytes();
		if (cfg_snap == '0) return 25'd1;
		if (cfg_snap > 25'(xdzc_pkg::MAX_SNAPSHOT_BYTES))
			return 25'(xdzc_pkg::MAX_SNAPSHOT_BYTES);
		return cfg_snap;
	endfunction

	function automatic logic [9:0] bmap_len_bytes(input logic [24:0] n);
		logic [12:0] chunks;
		chunks = 13'((26'(n) + 26'(xdzc_pkg::CHUNK_BYTES - 1))
			/ 26'(xdzc_pkg::CHUNK_BYTES));
		return 10'((chunks + 13'd7) / 13'd8);
	endfunction

	// Header, bitmap and data together
	function automatic logic [25:0] image_need(input logic [24:0] n);
		return 26'(xdzc_pkg::HDR_BYTES) + 26'(bmap_len_bytes(n)) + 26'(n);
	endfunction

	function automatic void restart_snapshot();
		word_idx  = '0;
		chunk_idx = '0;
		store_pos = '0;
		chunk_hit = 1'b0;
		bmap_acc  = '0;
		cap_good  = ({1'b0, cfg_cap} >= image_need(eff_bytes()));
	endfunction

	function automatic xdzc_pkg::out_t make_write(input xdzc_pkg::kind_t k,
			input logic [24:0] a, input logic [63:0] d, input logic [3:0] nbytes);
		xdzc_pkg::out_t w;
		w.out_kind    = k;
		w.out_addr    = a;
		w.out_payload = d;
		w.out_bytes   = nbytes;
		w.run_last    = 1'b0;
		return w;
	endfunction

	// Apply one register write; an index past the list changes nothing
	function automatic void model_register(input logic [xdzc_pkg::CFG_INDEX_W-1:0] idx,
			input logic [xdzc_pkg::CFG_DATA_W-1:0] val);
		unique case (idx)
			xdzc_pkg::REG_DELTA_MODE:     cfg_delta = val[0];
			xdzc_pkg::REG_SNAPSHOT_BYTES: cfg_snap = val;
			xdzc_pkg::REG_DEST_CAPACITY:  cfg_cap = val;
			default:                      return;
		endcase
		restart_snapshot();
	endfunction

	// Code one snapshot word and queue the writes it yields
	task automatic encode_word(input logic [63:0] st, input logic [63:0] rf);
		logic [24:0]    n;
		logic [25:0]    base;
		logic [25:0]    start;
		logic [24:0]    rem;
		logic [3:0]     nb;
		logic [63:0]    v;
		logic [21:0]    woff;
		logic [24:0]    cstart;
		logic [24:0]    span;
		bit             last;
		xdzc_pkg::out_t step_q[$];
		xdzc_pkg::out_t w;
		n = eff_bytes();
		base = 26'(xdzc_pkg::HDR_BYTES) + 26'(bmap_len_bytes(n));
		start = 26'({word_idx, 3'b000});
		rem = (start < 26'(n)) ? 25'(26'(n) - start) : 25'd1;
		nb = (rem >= 25'd8) ? 4'd8 : 4'(rem);
		v = cfg_delta ? (st ^ rf) : st;
		woff = word_idx - 22'(chunk_idx) * 22'(CHUNK_WORDS);
		last = (start + 26'd8 >= 26'(n));
		// drop the bytes past the end of the snapshot
		if (nb < 4'd8) v &= (64'd1 << (8 * nb)) - 64'd1;
		if (v != '0) chunk_hit = 1'b1;
		if (cap_good)
			step_q.push_back(make_write(xdzc_pkg::KIND_PAYLOAD,
				25'(base + 26'(store_pos) + 26'({woff, 3'b000})), v, nb));
		// chunk closes: advance past it only if it held data
		if (last || int'(woff) + 1 >= CHUNK_WORDS) begin
			cstart = 25'(chunk_idx) * 25'(xdzc_pkg::CHUNK_BYTES);
			span = last ? (n - cstart) : 25'(xdzc_pkg::CHUNK_BYTES);
			if (chunk_hit) begin
				bmap_acc |= 8'd1 << chunk_idx[2:0];
				store_pos = store_pos + span;
			end
			if (chunk_idx[2:0] == 3'd7 || last) begin
				if (cap_good)
					step_q.push_back(make_write(xdzc_pkg::KIND_BITMAP,
						25'(xdzc_pkg::HDR_BYTES) + 25'(chunk_idx >> 3),
						64'(bmap_acc), 4'd1));
				bmap_acc = '0;
			end
			chunk_hit = 1'b0;
			chunk_idx = chunk_idx + 12'd1;
		end
		word_idx = word_idx + 22'd1;
		if (last) begin
			if (cap_good) begin
				step_q.push_back(make_write(xdzc_pkg::KIND_HEADER, 25'd0,
					{7'd0, n, xdzc_pkg::HDR_MAGIC}, 4'd8));
				step_q.push_back(make_write(xdzc_pkg::KIND_HEADER, 25'd8,
					64'(xdzc_pkg::CHUNK_BYTES), 4'd4));
			end
			step_q.push_back(make_write(xdzc_pkg::KIND_DONE, 25'd0,
				cap_good ? 64'(base + 26'(store_pos)) : 64'd0, 4'd0));
			restart_snapshot();
		end
		if (step_q.size() != 0) begin
			w = step_q.pop_back();
			w.run_last = 1'b1;
			step_q.push_back(w);
		end
		foreach (step_q[i]) pending_writes.push_back(step_q[i]);
	endtask

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	task automatic note_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		err_count++;
		$display("MISMATCH %s at %0t: got %h, expected %h", what, $realtime, got, want);
	endtask

	// Compare every accepted write with the oldest prediction
	always @(posedge clk) begin
		xdzc_pkg::out_t want;
		if (arst_n && out_valid && !out_stall) begin
			writes_seen++;
			if (out_item.out_kind == xdzc_pkg::KIND_DONE) runs_done++;
			if (pending_writes.size() == 0) begin
				note_mismatch("unexpected write", 64'(out_item.out_addr),
					64'(out_item.out_kind));
			end else begin
				want = pending_writes.pop_front();
				if (out_item.out_kind !== want.out_kind)
					note_mismatch("out_kind", 64'(out_item.out_kind), 64'(want.out_kind));
				if (out_item.out_addr !== want.out_addr)
					note_mismatch("out_addr", 64'(out_item.out_addr), 64'(want.out_addr));
				if (out_item.out_payload !== want.out_payload)
					note_mismatch("out_payload", out_item.out_payload, want.out_payload);
				if (out_item.out_bytes !== want.out_bytes)
					note_mismatch("out_bytes", 64'(out_item.out_bytes), 64'(want.out_bytes));
				if (out_item.run_last !== want.run_last)
					note_mismatch("run_last", 64'(out_item.run_last), 64'(want.run_last));
			end
		end
	end

	// Stall the write port in bursts of random length
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (bursty && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 7);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// End the run if nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	// Offer one request, maybe after an idle burst; hold it until taken
	task automatic push_word(input logic [63:0] st, input logic [63:0] rf);
		@(negedge clk);
		if (bursty && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{state_word: st, reference_word: rf};
		do @(posedge clk); while (in_stall !== 1'b0);
		encode_word(st, rf);
		words_sent++;
	endtask

	// Drop valid, drain all predicted writes, settle, then write one register
	task automatic write_register(input logic [xdzc_pkg::CFG_INDEX_W-1:0] idx,
			input logic [xdzc_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_writes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		model_register(idx, val);
		cfg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Pick a word; a silent word codes to zero in the current mode
	task automatic pick_word(input bit silent, output logic [63:0] st,
			output logic [63:0] rf);
		logic [63:0] coded;
		rf = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0:       coded = 64'($urandom_range(1, 255)) << (8 * $urandom_range(0, 7));
			1:       coded = '1;
			2:       coded = 64'd1 << $urandom_range(0, 63);
			default: coded = {$urandom, $urandom};
		endcase
		if (silent) coded = '0;
		st = cfg_delta ? (coded ^ rf) : coded;
	endtask

	// Short snapshots under random settings, some cut short by a register write
	task automatic short_phases(input int target);
		int first;
		int runs;
		int words;
		int cut;
		int spare_at;
		logic [24:0] len;
		logic [25:0] need;
		logic [24:0] cap;
		bit zero_run;
		logic [63:0] st;
		logic [63:0] rf;
		first = words_sent;
		while (words_sent - first < target) begin
			write_register(xdzc_pkg::REG_DELTA_MODE, 25'($urandom_range(0, 1)));
			case ($urandom_range(0, 9))
				0:       len = 25'd0;
				1:       len = 25'd1;
				2, 3:    len = 25'(8 * $urandom_range(1, 8));
				default: len = 25'($urandom_range(2, 120));
			endcase
			write_register(xdzc_pkg::REG_SNAPSHOT_BYTES, len);
			need = image_need(eff_bytes());
			case ($urandom_range(0, 5))
				0:       cap = 25'(need - 26'd1);
				1:       cap = 25'(need);
				2:       cap = 25'($urandom_range(0, int'(need)));
				default: cap = '1;
			endcase
			write_register(xdzc_pkg::REG_DEST_CAPACITY, cap);
			runs = $urandom_range(1, 3);
			for (int r = 0; r < runs; r++) begin
				words = (int'(eff_bytes()) + 7) / 8;
				cut = words;
				if (r == runs - 1 && words > 1 && $urandom_range(0, 5) == 0)
					cut = $urandom_range(1, words - 1);
				spare_at = (words > 1 && $urandom_range(0, 7) == 0) ?
					$urandom_range(1, words - 1) : -1;
				zero_run = ($urandom_range(0, 3) == 0);
				for (int i = 0; i < cut; i++) begin
					if (i == spare_at) write_register(REG_SPARE_INDEX, 25'($urandom));
					pick_word(zero_run || $urandom_range(0, 3) == 0, st, rf);
					push_word(st, rf);
				end
			end
		end
	endtask

	// Opening words of a snapshot of nine chunks; the next register write
	// cuts it off
	task automatic long_snapshot();
		logic [24:0] len;
		bit silent;
		logic [63:0] st;
		logic [63:0] rf;
		len = 25'(8 * xdzc_pkg::CHUNK_BYTES + $urandom_range(1, xdzc_pkg::CHUNK_BYTES));
		write_register(xdzc_pkg::REG_DELTA_MODE, 25'($urandom_range(0, 1)));
		write_register(xdzc_pkg::REG_SNAPSHOT_BYTES, len);
		write_register(xdzc_pkg::REG_DEST_CAPACITY, '1);
		for (int i = 0; i < LONG_WORDS; i++) begin
			silent = ($urandom_range(0, 3) == 0);
			pick_word(silent, st, rf);
			push_word(st, rf);
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		xdzc_pkg::out_t w;
		// model follows the reset values; the capacity fits the image exactly
		cfg_delta = 1'b0;
		cfg_snap  = xdzc_pkg::RESET_SNAPSHOT_BYTES;
		cfg_cap   = xdzc_pkg::RESET_DEST_CAPACITY;
		restart_snapshot();
		cap_good  = 1'b1;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed rows; pin the completion where the row types it in
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_tab[i].op == ROW_CFG) begin
				write_register(dir_tab[i].idx, dir_tab[i].val);
			end else begin
				push_word(dir_tab[i].st, dir_tab[i].rf);
				if (dir_tab[i].typed) begin
					if (pending_writes.size() != 0
							&& pending_writes[$].out_kind == xdzc_pkg::KIND_DONE) begin
						w = pending_writes.pop_back();
						w.out_payload = dir_tab[i].total;
						pending_writes.push_back(w);
					end else begin
						note_mismatch("directed row closes no snapshot", 64'(i),
							dir_tab[i].total);
					end
				end
			end
		end

		// Random part: idle bursts first, then a clean stretch at full rate
		short_phases(115);
		long_snapshot();
		short_phases(40);
		bursty = 1'b0;
		short_phases(50);

		// Release the input, drain, and give stray writes a chance to show up
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_writes.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d snapshot words and %0d register writes", words_sent,
			cfg_writes);
		$display("Checked %0d writes, %0d snapshot completions", writes_seen, runs_done);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
